@@ src/list_equal_or_permutation_check_core_macros.svh @@
// Assertion helpers for the checker core RTL.
`ifndef LIST_EQUAL_OR_PERMUTATION_CHECK_CORE_MACROS_SVH
`define LIST_EQUAL_OR_PERMUTATION_CHECK_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LEPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LEPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/lepc_pkg.sv @@
package lepc_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int FILL_W     = 5;
  localparam int WORD_W     = 32;

  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam logic [1:0] ACT_FIRST   = 2'd0;
  localparam logic [1:0] ACT_SECOND  = 2'd1;
  localparam logic [1:0] ACT_COMPARE = 2'd2;

  typedef enum logic [1:0] {
    VERDICT_EQUAL = 2'd0,
    VERDICT_EQUIV = 2'd1,
    VERDICT_DIFF  = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ORD,
    S_KEY,
    S_CNT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic     busy;
    logic     done;
    verdict_t verdict;
  } status_t;

endpackage

@@ src/list_equal_or_permutation_check_core.sv @@
// Two-list equality / permutation checker. Issue an item by raising start
// while busy is low; action 0 appends value to the first list, 1 to the
// second, 2 compares and then empties both lists (3 is ignored). Each list
// holds LIST_DEPTH entries; appends to a full list are dropped and flagged.
// A compare gives exactly one result: done is high for a single cycle with
// verdict, both lengths and the dropped flag, and the receiver cannot stall
// it, so capture it on that cycle. Appends are taken one per cycle, back to
// back, while busy is low. A compare keeps busy high while the sequencer
// walks the two list RAMs through their single read ports: it skips the
// scan if the lengths differ or both lists are empty, makes one in-order
// pass if the lists match in order, and else runs the permutation check,
// which reads one first-list key and then scans both lists once per key.
module list_equal_or_permutation_check_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [31:0] value,
  output logic        done,
  output logic [1:0]  verdict,
  output logic [4:0]  first_length,
  output logic [4:0]  second_length,
  output logic        dropped
);

`include "list_equal_or_permutation_check_core_macros.svh"

  localparam lepc_pkg::fill_t FULL = lepc_pkg::fill_t'(lepc_pkg::LIST_DEPTH);

  lepc_pkg::status_t status;
  lepc_pkg::fill_t   first_fill;
  lepc_pkg::fill_t   second_fill;
  logic              drop_flag;
  lepc_pkg::addr_t   addr_a;
  lepc_pkg::addr_t   addr_b;
  lepc_pkg::word_t   a_q;
  lepc_pkg::word_t   b_q;

  // transfer of one item into the block
  logic acc;
  logic acc_first;
  logic acc_second;
  logic acc_cmp;
  logic we_a;
  logic we_b;

  assign acc        = start && !status.busy;
  assign acc_first  = acc && (action == lepc_pkg::ACT_FIRST);
  assign acc_second = acc && (action == lepc_pkg::ACT_SECOND);
  assign acc_cmp    = acc && (action == lepc_pkg::ACT_COMPARE);
  assign we_a       = acc_first && (first_fill != FULL);
  assign we_b       = acc_second && (second_fill != FULL);

  // Fill counts and overflow flag. The compare clears them on the transfer
  // cycle; the sequencer keeps its own copy of the length, and busy blocks
  // appends until it is done, so RAM writes never overlap the scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_fill  <= '0;
      second_fill <= '0;
      drop_flag   <= 1'b0;
    end else if (acc_cmp) begin
      first_fill  <= '0;
      second_fill <= '0;
      drop_flag   <= 1'b0;
    end else begin
      if (we_a) begin
        first_fill <= first_fill + lepc_pkg::fill_t'(1);
      end
      if (we_b) begin
        second_fill <= second_fill + lepc_pkg::fill_t'(1);
      end
      if ((acc_first && !we_a) || (acc_second && !we_b)) begin
        drop_flag <= 1'b1;
      end
    end
  end

  // Result fields that are known at the compare transfer.
  always_ff @(posedge clk) begin
    if (acc_cmp) begin
      first_length  <= first_fill;
      second_length <= second_fill;
      dropped       <= drop_flag;
    end
  end

  lepc_ram #(
    .WIDTH (lepc_pkg::WORD_W),
    .DEPTH (lepc_pkg::LIST_DEPTH)
  ) u_first_ram (
    .clk   (clk),
    .we    (we_a),
    .waddr (first_fill[lepc_pkg::ADDR_W-1:0]),
    .wdata (value),
    .raddr (addr_a),
    .rdata (a_q)
  );

  lepc_ram #(
    .WIDTH (lepc_pkg::WORD_W),
    .DEPTH (lepc_pkg::LIST_DEPTH)
  ) u_second_ram (
    .clk   (clk),
    .we    (we_b),
    .waddr (second_fill[lepc_pkg::ADDR_W-1:0]),
    .wdata (value),
    .raddr (addr_b),
    .rdata (b_q)
  );

  lepc_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .go          (acc_cmp),
    .first_fill  (first_fill),
    .second_fill (second_fill),
    .a_q         (a_q),
    .b_q         (b_q),
    .addr_a      (addr_a),
    .addr_b      (addr_b),
    .status      (status)
  );

  assign busy    = status.busy;
  assign done    = status.done;
  assign verdict = status.verdict;

  `LEPC_ASSERT_NOW(a_done_busy, clk, rst, done, busy, "result strobe outside a compare")
  `LEPC_ASSERT_NEXT(a_cmp_busy, clk, rst, acc_cmp, busy && first_fill == '0, "compare did not start")
  `LEPC_ASSERT_NEXT(a_full_drop, clk, rst, acc_first && first_fill == FULL, drop_flag, "lost drop")
  `LEPC_ASSERT_NOW(a_fill_range, clk, rst, 1'b1, first_fill <= FULL && second_fill <= FULL, "fill")

endmodule

@@ src/lepc_ram.sv @@
module lepc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/lepc_engine.sv @@
// Compare sequencer: order pass over both stores, then on a mismatch a count pass per first-list key.
module lepc_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  lepc_pkg::fill_t   first_fill,
  input  lepc_pkg::fill_t   second_fill,
  input  lepc_pkg::word_t   a_q,
  input  lepc_pkg::word_t   b_q,
  output lepc_pkg::addr_t   addr_a,
  output lepc_pkg::addr_t   addr_b,
  output lepc_pkg::status_t status
);

  lepc_pkg::state_t   state, state_next;
  lepc_pkg::fill_t    len, len_next;
  lepc_pkg::fill_t    i_idx, i_idx_next;
  lepc_pkg::fill_t    j_idx, j_idx_next;
  lepc_pkg::fill_t    cnt_a, cnt_a_next;
  lepc_pkg::fill_t    cnt_b, cnt_b_next;
  lepc_pkg::word_t    key, key_next;
  logic               key_pend, key_pend_next;
  logic               rd_vld, rd_vld_next;
  logic               rd_last, rd_last_next;
  logic               mism, mism_next;
  lepc_pkg::verdict_t verdict, verdict_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lepc_pkg::S_IDLE;
      rd_vld   <= 1'b0;
      rd_last  <= 1'b0;
      key_pend <= 1'b0;
    end else begin
      state    <= state_next;
      rd_vld   <= rd_vld_next;
      rd_last  <= rd_last_next;
      key_pend <= key_pend_next;
    end
    len     <= len_next;
    i_idx   <= i_idx_next;
    j_idx   <= j_idx_next;
    cnt_a   <= cnt_a_next;
    cnt_b   <= cnt_b_next;
    key     <= key_next;
    mism    <= mism_next;
    verdict <= verdict_next;
  end

  always_comb begin
    logic            iss;
    logic            mism_now;
    lepc_pkg::fill_t ca;
    lepc_pkg::fill_t cb;
    state_next    = state;
    len_next      = len;
    i_idx_next    = i_idx;
    j_idx_next    = j_idx;
    cnt_a_next    = cnt_a;
    cnt_b_next    = cnt_b;
    key_next      = key;
    mism_next     = mism;
    verdict_next  = verdict;
    rd_vld_next   = 1'b0;
    rd_last_next  = 1'b0;
    key_pend_next = 1'b0;
    iss           = (j_idx < len);
    mism_now      = mism | (a_q != b_q);
    ca            = cnt_a + lepc_pkg::fill_t'(a_q == key);
    cb            = cnt_b + lepc_pkg::fill_t'(b_q == key);

    case (state)
      lepc_pkg::S_IDLE: begin
        if (go) begin
          len_next   = first_fill;
          j_idx_next = '0;
          mism_next  = 1'b0;
          if (first_fill != second_fill) begin
            verdict_next = lepc_pkg::VERDICT_DIFF;
            state_next   = lepc_pkg::S_DONE;
          end else if (first_fill == '0) begin
            verdict_next = lepc_pkg::VERDICT_EQUAL;
            state_next   = lepc_pkg::S_DONE;
          end else begin
            state_next = lepc_pkg::S_ORD;
          end
        end
      end
      lepc_pkg::S_ORD: begin
        if (iss) begin
          j_idx_next   = j_idx + lepc_pkg::fill_t'(1);
          rd_vld_next  = 1'b1;
          rd_last_next = (j_idx == len - lepc_pkg::fill_t'(1));
        end
        if (rd_vld) begin
          mism_next = mism_now;
          if (rd_last) begin
            if (!mism_now) begin
              verdict_next = lepc_pkg::VERDICT_EQUAL;
              state_next   = lepc_pkg::S_DONE;
            end else begin
              i_idx_next = '0;
              state_next = lepc_pkg::S_KEY;
            end
          end
        end
      end
      lepc_pkg::S_KEY: begin
        // first[i] is read this cycle and captured on the first count cycle
        j_idx_next    = '0;
        cnt_a_next    = '0;
        cnt_b_next    = '0;
        key_pend_next = 1'b1;
        state_next    = lepc_pkg::S_CNT;
      end
      lepc_pkg::S_CNT: begin
        if (key_pend) begin
          key_next = a_q;
        end
        if (iss) begin
          j_idx_next   = j_idx + lepc_pkg::fill_t'(1);
          rd_vld_next  = 1'b1;
          rd_last_next = (j_idx == len - lepc_pkg::fill_t'(1));
        end
        if (rd_vld) begin
          cnt_a_next = ca;
          cnt_b_next = cb;
          if (rd_last) begin
            if (ca != cb) begin
              verdict_next = lepc_pkg::VERDICT_DIFF;
              state_next   = lepc_pkg::S_DONE;
            end else if (i_idx == len - lepc_pkg::fill_t'(1)) begin
              verdict_next = lepc_pkg::VERDICT_EQUIV;
              state_next   = lepc_pkg::S_DONE;
            end else begin
              i_idx_next = i_idx + lepc_pkg::fill_t'(1);
              state_next = lepc_pkg::S_KEY;
            end
          end
        end
      end
      lepc_pkg::S_DONE: begin
        state_next = lepc_pkg::S_IDLE;
      end
      default: begin
        state_next = lepc_pkg::S_IDLE;
      end
    endcase
  end

  assign addr_a = (state == lepc_pkg::S_KEY) ? i_idx[lepc_pkg::ADDR_W-1:0]
                                              : j_idx[lepc_pkg::ADDR_W-1:0];
  assign addr_b = j_idx[lepc_pkg::ADDR_W-1:0];

  assign status.busy    = (state != lepc_pkg::S_IDLE);
  assign status.done    = (state == lepc_pkg::S_DONE);
  assign status.verdict = verdict;

endmodule

@@ dv/list_check_scoreboard_pkg.sv @@
package list_check_scoreboard_pkg;
  import lepc_pkg::*;

  typedef struct {
    verdict_t verdict;
    fill_t    first_len;
    fill_t    second_len;
    logic     dropped;
  } list_verdict_t;

  class list_check_scoreboard;
    word_t         first_words[LIST_DEPTH];
    word_t         second_words[LIST_DEPTH];
    fill_t         first_fill;
    fill_t         second_fill;
    logic          overflow_seen;
    list_verdict_t awaited[$];
    int            mismatches;

    function new();
      first_fill    = '0;
      second_fill   = '0;
      overflow_seen = 1'b0;
      mismatches    = 0;
    endfunction

    // How often key occurs among the held entries of one list.
    function int hits(bit in_second, word_t key);
      int n;
      n = 0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
        if (in_second) begin
          if (i < second_fill && second_words[i] == key) n++;
        end else if (i < first_fill && first_words[i] == key) begin
          n++;
        end
      end
      return n;
    endfunction

    // Called for every accepted input transfer.
    function void note(logic [1:0] act, word_t val);
      list_verdict_t rec;
      bit            same;
      case (act)
        ACT_FIRST: begin
          if (first_fill < LIST_DEPTH) begin
            first_words[first_fill] = val;
            first_fill++;
          end else begin
            overflow_seen = 1'b1;
          end
        end
        ACT_SECOND: begin
          if (second_fill < LIST_DEPTH) begin
            second_words[second_fill] = val;
            second_fill++;
          end else begin
            overflow_seen = 1'b1;
          end
        end
        ACT_COMPARE: begin
          rec.first_len  = first_fill;
          rec.second_len = second_fill;
          rec.dropped    = overflow_seen;
          if (first_fill != second_fill) begin
            rec.verdict = VERDICT_DIFF;
          end else begin
            same = 1'b1;
            for (int i = 0; i < first_fill; i++) begin
              if (first_words[i] != second_words[i]) same = 1'b0;
            end
            if (same) begin
              rec.verdict = VERDICT_EQUAL;
            end else begin
              rec.verdict = VERDICT_EQUIV;
              for (int i = 0; i < first_fill; i++) begin
                if (hits(1'b0, first_words[i]) != hits(1'b1, first_words[i]))
                  rec.verdict = VERDICT_DIFF;
              end
            end
          end
          awaited.push_back(rec);
          first_fill    = '0;
          second_fill   = '0;
          overflow_seen = 1'b0;
        end
        default: ;  // unused code, no effect
      endcase
    endfunction

    // Called for every result strobe.
    function void check(logic [1:0] got_verdict, fill_t got_first, fill_t got_second,
                        logic got_dropped);
      list_verdict_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: verdict %0d lengths %0d/%0d dropped %0b",
                   got_verdict, got_first, got_second, got_dropped);
        return;
      end
      want = awaited.pop_front();
      if (got_verdict !== want.verdict || got_first !== want.first_len ||
          got_second !== want.second_len || got_dropped !== want.dropped) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected verdict %0d lengths %0d/%0d dropped %0b, got verdict %0d lengths %0d/%0d dropped %0b",
                   want.verdict, want.first_len, want.second_len, want.dropped,
                   got_verdict, got_first, got_second, got_dropped);
      end
    endfunction
  endclass

endpackage

@@ dv/testbench.sv @@
module testbench;
  import lepc_pkg::*;
  import list_check_scoreboard_pkg::*;

  // Shapes of one load-then-compare sequence.
  typedef enum int {
    SEQ_EQUAL,
    SEQ_PERMUTED,
    SEQ_ONE_CHANGED,
    SEQ_COUNT_SKEW,
    SEQ_RANDOM,
    SEQ_LEN_MISMATCH,
    SEQ_NOISE
  } seq_kind_t;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int         ITEM_TARGET = 1450;
  localparam int         CALM_TAIL   = 200;   // last items go without idling
  localparam word_t      WORD_MIN    = 32'h8000_0000;
  localparam word_t      WORD_MAX    = 32'h7fff_ffff;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  action;
  logic [31:0] value;
  logic        done;
  logic [1:0]  verdict;
  logic [4:0]  first_length;
  logic [4:0]  second_length;
  logic        dropped;

  list_check_scoreboard verdicts;
  int                   items_sent;   // counts actions 0..2 only
  bit                   idle_on;

  list_equal_or_permutation_check_core dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .value         (value),
    .done          (done),
    .verdict       (verdict),
    .first_length  (first_length),
    .second_length (second_length),
    .dropped       (dropped)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop. Even if every transfer were as slow as a full-length compare
  // plus a max idle burst, the run stays well inside.
  initial begin
    #30_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Results can't be stalled: grab every strobe on the edge that ends it.
  always @(posedge clk) begin
    if (!rst && done) verdicts.check(verdict, first_length, second_length, dropped);
  end

  // One input transfer. Inputs move on the falling edge; the transfer
  // happens on the first rising edge with busy low. start is only lowered
  // on a negedge where it is not raised again.
  task automatic issue(input logic [1:0] act, input word_t val);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start  <= 1'b1;
    action <= act;
    value  <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    verdicts.note(act, val);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  // Hold off the sender until every pending verdict is back.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (verdicts.awaited.size() != 0) @(posedge clk);
  endtask

  // Narrow values repeat often so permutations and count skews show up;
  // wide values sweep every bit.
  function automatic word_t pick_value(bit narrow);
    word_t pool[6] = '{WORD_MIN, WORD_MAX, 32'h0, 32'hffff_ffff, 32'h5555_aaaa, 32'h1};
    if (!narrow) return $urandom;
    if ($urandom_range(0, 2) == 0) return pool[$urandom_range(0, 5)];
    return word_t'($urandom_range(0, 3));
  endfunction

  task automatic shuffle(ref word_t q[$]);
    word_t t;
    int    j;
    for (int i = q.size() - 1; i > 0; i--) begin
      j    = $urandom_range(0, i);
      t    = q[i];
      q[i] = q[j];
      q[j] = t;
    end
  endtask

  task automatic run_sequence(input seq_kind_t kind);
    word_t la[$];
    word_t lb[$];
    int    n1;
    int    ia;
    int    ib;
    int    k;
    bit    narrow;
    if (kind == SEQ_NOISE) begin
      // stray transfers, any code, no closing compare
      repeat ($urandom_range(1, 4)) issue(2'($urandom_range(0, 3)), $urandom);
      return;
    end
    narrow = ($urandom_range(0, 2) != 0);
    // mostly short lists; now and then full or overfull
    case ($urandom_range(0, 15))
      0:       n1 = LIST_DEPTH;
      1:       n1 = $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 4);
      2, 3:    n1 = $urandom_range(7, LIST_DEPTH - 1);
      default: n1 = $urandom_range(0, 6);
    endcase
    for (int i = 0; i < n1; i++) la.push_back(pick_value(narrow));
    lb = la;
    case (kind)
      SEQ_PERMUTED: shuffle(lb);
      SEQ_ONE_CHANGED: begin
        if ($urandom_range(0, 1)) shuffle(lb);
        if (n1 > 0) lb[$urandom_range(0, n1 - 1)] = pick_value(narrow);
      end
      SEQ_COUNT_SKEW: begin
        // same keys, one count shifted: e.g. x x y against x y y
        shuffle(lb);
        if (n1 > 1) begin
          k     = $urandom_range(0, n1 - 1);
          lb[k] = lb[$urandom_range(0, n1 - 1)];
        end
      end
      SEQ_RANDOM: begin
        lb.delete();
        for (int i = 0; i < n1; i++) lb.push_back(pick_value(narrow));
      end
      SEQ_LEN_MISMATCH: begin
        if ($urandom_range(0, 1)) shuffle(lb);
        if (lb.size() > 0 && $urandom_range(0, 1)) void'(lb.pop_back());
        else lb.push_back(pick_value(narrow));
      end
      default: ;
    endcase
    // interleave the two lists; order only matters within a list
    ia = 0;
    ib = 0;
    while (ia < la.size() || ib < lb.size()) begin
      if ($urandom_range(0, 19) == 0) issue(ACT_UNUSED, $urandom);
      if (ib >= lb.size() || (ia < la.size() && $urandom_range(0, 1))) begin
        issue(ACT_FIRST, la[ia]);
        ia++;
      end else begin
        issue(ACT_SECOND, lb[ib]);
        ib++;
      end
    end
    issue(ACT_COMPARE, $urandom);
  endtask

  initial begin
    verdicts   = new();
    rst        = 1'b1;
    start      = 1'b0;
    action     = ACT_FIRST;
    value      = '0;
    items_sent = 0;
    idle_on    = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed: compare with both lists empty, unused code, overfull list
    // with extreme values, a permutation of extremes, and a count skew.
    issue(ACT_COMPARE, WORD_MAX);
    issue(ACT_UNUSED, 32'hffff_ffff);
    for (int i = 0; i <= LIST_DEPTH; i++) begin
      case (i % 4)
        0:       issue(ACT_FIRST, WORD_MIN);
        1:       issue(ACT_FIRST, WORD_MAX);
        2:       issue(ACT_FIRST, 32'h0);
        default: issue(ACT_FIRST, 32'hffff_ffff);
      endcase
    end
    issue(ACT_COMPARE, '0);
    issue(ACT_FIRST, WORD_MIN);
    issue(ACT_FIRST, WORD_MAX);
    issue(ACT_SECOND, WORD_MAX);
    issue(ACT_SECOND, WORD_MIN);
    issue(ACT_COMPARE, '0);
    issue(ACT_FIRST, 32'd5);
    issue(ACT_FIRST, 32'd5);
    issue(ACT_FIRST, 32'd6);
    issue(ACT_SECOND, 32'd6);
    issue(ACT_SECOND, 32'd5);
    issue(ACT_SECOND, 32'd6);
    issue(ACT_COMPARE, '0);
    drain();

    // Random sequences; idling per sequence, none in the tail.
    while (items_sent < ITEM_TARGET) begin
      idle_on = (items_sent < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      run_sequence(seq_kind_t'($urandom_range(0, 6)));
      if ($urandom_range(0, 11) == 0) drain();
    end

    @(negedge clk);
    start <= 1'b0;
    while (verdicts.awaited.size() != 0) @(posedge clk);
    repeat (320) @(posedge clk);
    if (verdicts.mismatches == 0 && verdicts.awaited.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
